// ----- src/flm_pkg.sv -----
// Shared types and constants for the FIFO lock manager.
`timescale 1ns / 1ps

package flm_pkg;

	localparam int NUM_RESOURCES_DEF = 16;
	localparam int QUEUE_DEPTH_DEF   = 8;

	localparam int ACTION_W    = 3;
	localparam int CLIENT_W    = 8;
	localparam int RES_FIELD_W = 4;
	localparam int VALUE_W     = 32;
	localparam int RES_CODES   = 2 ** RES_FIELD_W;

	localparam logic [ACTION_W-1:0] ACT_LOCK   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_READ   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_UNLOCK = 3'd3;

	typedef enum logic [3:0] {
		ST_GRANTED       = 4'd0,
		ST_WRITE_OK      = 4'd1,
		ST_WRITE_DENIED  = 4'd2,
		ST_READ_OK       = 4'd3,
		ST_READ_DENIED   = 4'd4,
		ST_UNLOCKED      = 4'd5,
		ST_UNLOCK_DENIED = 4'd6,
		ST_UNKNOWN_OP    = 4'd7,
		ST_QUEUE_FULL    = 4'd8
	} status_t;

	typedef struct packed {
		logic [ACTION_W-1:0]    action;
		logic [CLIENT_W-1:0]    client_id;
		logic [RES_FIELD_W-1:0] resource_id;
		logic [VALUE_W-1:0]     write_value;
	} req_t;

	typedef struct packed {
		logic [CLIENT_W-1:0] dest_client;
		status_t             status;
		logic [VALUE_W-1:0]  read_value;
		logic                last;
	} rsp_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_LOOK,
		FSM_EMIT,
		FSM_GRANT
	} fsm_t;

endpackage

// ----- src/flm_chan_if.sv -----
// Valid/ready channel carrying one item of type T.
`timescale 1ns / 1ps

interface flm_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/flm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module flm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ----- src/fifo_lock_manager_unit.sv -----
// Top level of the FIFO lock manager: record memory, waiter memory and control.
`timescale 1ns / 1ps

// Per-resource owner, value, queue head and count live in one record RAM; the
// waiting clients live in a second RAM, QUEUE_DEPTH slots per resource. An
// item is accepted with its record read, then the record read-modify-write
// and reply follow; an unlock that hands the lock to a waiter adds a GRANT
// state for the waiter RAM read data and the second reply. A full output
// register stalls the reply until it drains. After reset a clearing pass
// over all NUM_RESOURCES records zeroes the record RAM, during which no
// request is accepted. Resource ids are taken modulo NUM_RESOURCES.
module fifo_lock_manager_unit #(
	parameter int NUM_RESOURCES = flm_pkg::NUM_RESOURCES_DEF,
	parameter int QUEUE_DEPTH   = flm_pkg::QUEUE_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	flm_chan_if.sink    req,
	flm_chan_if.source  rsp
);
	localparam int RIDX_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
	localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int WDEPTH  = NUM_RESOURCES * QUEUE_DEPTH;
	localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

	typedef struct packed {
		logic                         owned;
		logic [flm_pkg::CLIENT_W-1:0] owner;
		logic [QIDX_W-1:0]            head;
		logic [CNT_W-1:0]             count;
		logic [flm_pkg::VALUE_W-1:0]  value;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	flm_pkg::fsm_t state_q, state_d;

	logic [RIDX_W-1:0]            rmod_tab [flm_pkg::RES_CODES];
	logic [RIDX_W-1:0]            clr_q;
	logic [flm_pkg::ACTION_W-1:0] act_q;
	logic [flm_pkg::CLIENT_W-1:0] cli_q;
	logic [RIDX_W-1:0]            r_q;
	logic [flm_pkg::VALUE_W-1:0]  wv_q;
	flm_pkg::rsp_t                pend_q;
	logic                         grant_q;
	rec_t                         upd_q;
	logic                         out_valid_q;
	flm_pkg::rsp_t                out_data_q;

	rec_t                         rec_rd;
	logic                         rec_re, rec_we;
	logic [RIDX_W-1:0]            rec_waddr;
	rec_t                         rec_wdata;
	logic [flm_pkg::CLIENT_W-1:0] wt_rd;
	logic                         wt_we, wt_re;

	flm_pkg::rsp_t                dec_rsp;
	logic                         dec_has_rsp, dec_rec_we, dec_wt_we, dec_wt_re, dec_grant;
	rec_t                         dec_rec;
	logic                         is_owner;
	logic [SUM_W-1:0]             tail_sum;
	logic [QIDX_W-1:0]            tail, head_nx;
	logic [WADDR_W-1:0]           wt_addr;

	logic                         slot_free, load_out;
	flm_pkg::rsp_t                out_d;

	for (genvar i = 0; i < flm_pkg::RES_CODES; i++) begin : g_rmod
		assign rmod_tab[i] = RIDX_W'(i % NUM_RESOURCES);
	end

	flm_ram #(.WIDTH(REC_W), .DEPTH(NUM_RESOURCES)) u_rec_ram (
		.clk     (clk),
		.wr_en   (rec_we),
		.wr_addr (rec_waddr),
		.wr_data (rec_wdata),
		.rd_en   (rec_re),
		.rd_addr (rmod_tab[req.data.resource_id]),
		.rd_data (rec_rd)
	);

	flm_ram #(.WIDTH(flm_pkg::CLIENT_W), .DEPTH(WDEPTH)) u_wait_ram (
		.clk     (clk),
		.wr_en   (wt_we),
		.wr_addr (wt_addr),
		.wr_data (cli_q),
		.rd_en   (wt_re),
		.rd_addr (wt_addr),
		.rd_data (wt_rd)
	);

	// queue arithmetic
	always_comb begin
		is_owner = rec_rd.owned && (rec_rd.owner == cli_q);
		tail_sum = SUM_W'(rec_rd.head) + SUM_W'(rec_rd.count);
		if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
		end
		tail = QIDX_W'(tail_sum);
		head_nx = (rec_rd.head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : QIDX_W'(rec_rd.head + 1'b1);
		wt_addr = WADDR_W'(r_q) * WADDR_W'(QUEUE_DEPTH)
			+ WADDR_W'((act_q == flm_pkg::ACT_UNLOCK) ? rec_rd.head : tail);
	end

	// request decode against the fetched record
	always_comb begin
		dec_rsp.dest_client = cli_q;
		dec_rsp.status      = flm_pkg::ST_UNKNOWN_OP;
		dec_rsp.read_value  = '0;
		dec_rsp.last        = 1'b1;
		dec_has_rsp         = 1'b1;
		dec_rec_we          = 1'b0;
		dec_rec             = rec_rd;
		dec_wt_we           = 1'b0;
		dec_wt_re           = 1'b0;
		dec_grant           = 1'b0;
		case (act_q)
			flm_pkg::ACT_LOCK: begin
				if (!rec_rd.owned) begin
					dec_rec.owned  = 1'b1;
					dec_rec.owner  = cli_q;
					dec_rec_we     = 1'b1;
					dec_rsp.status = flm_pkg::ST_GRANTED;
				end else if (rec_rd.count >= CNT_W'(QUEUE_DEPTH)) begin
					dec_rsp.status = flm_pkg::ST_QUEUE_FULL;
				end else begin
					dec_rec.count = CNT_W'(rec_rd.count + 1'b1);
					dec_rec_we    = 1'b1;
					dec_wt_we     = 1'b1;
					dec_has_rsp   = 1'b0;
				end
			end
			flm_pkg::ACT_WRITE: begin
				if (is_owner) begin
					dec_rec.value  = wv_q;
					dec_rec_we     = 1'b1;
					dec_rsp.status = flm_pkg::ST_WRITE_OK;
				end else begin
					dec_rsp.status = flm_pkg::ST_WRITE_DENIED;
				end
			end
			flm_pkg::ACT_READ: begin
				if (is_owner) begin
					dec_rsp.status     = flm_pkg::ST_READ_OK;
					dec_rsp.read_value = rec_rd.value;
				end else begin
					dec_rsp.status = flm_pkg::ST_READ_DENIED;
				end
			end
			flm_pkg::ACT_UNLOCK: begin
				if (!is_owner) begin
					dec_rsp.status = flm_pkg::ST_UNLOCK_DENIED;
				end else if (rec_rd.count != '0) begin
					dec_rec.head   = head_nx;
					dec_rec.count  = CNT_W'(rec_rd.count - 1'b1);
					dec_wt_re      = 1'b1;
					dec_grant      = 1'b1;
					dec_rsp.status = flm_pkg::ST_UNLOCKED;
					dec_rsp.last   = 1'b0;
				end else begin
					dec_rec.owned  = 1'b0;
					dec_rec.owner  = '0;
					dec_rec_we     = 1'b1;
					dec_rsp.status = flm_pkg::ST_UNLOCKED;
				end
			end
			default: begin
				dec_rsp.status = flm_pkg::ST_UNKNOWN_OP;
			end
		endcase
	end

	assign slot_free = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			flm_pkg::FSM_CLEAR: begin
				if (clr_q == RIDX_W'(NUM_RESOURCES - 1)) begin
					state_d = flm_pkg::FSM_IDLE;
				end
			end
			flm_pkg::FSM_IDLE: begin
				if (req.valid) begin
					state_d = flm_pkg::FSM_LOOK;
				end
			end
			flm_pkg::FSM_LOOK: begin
				if (!dec_has_rsp) begin
					state_d = flm_pkg::FSM_IDLE;
				end else if (!slot_free) begin
					state_d = flm_pkg::FSM_EMIT;
				end else if (dec_grant) begin
					state_d = flm_pkg::FSM_GRANT;
				end else begin
					state_d = flm_pkg::FSM_IDLE;
				end
			end
			flm_pkg::FSM_EMIT: begin
				if (slot_free) begin
					state_d = grant_q ? flm_pkg::FSM_GRANT : flm_pkg::FSM_IDLE;
				end
			end
			flm_pkg::FSM_GRANT: begin
				if (slot_free) begin
					state_d = flm_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = flm_pkg::FSM_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		rec_re    = 1'b0;
		rec_we    = 1'b0;
		rec_waddr = r_q;
		rec_wdata = dec_rec;
		wt_we     = 1'b0;
		wt_re     = 1'b0;
		load_out  = 1'b0;
		out_d     = dec_rsp;
		case (state_q)
			flm_pkg::FSM_CLEAR: begin
				rec_we    = 1'b1;
				rec_waddr = clr_q;
				rec_wdata = '0;
			end
			flm_pkg::FSM_IDLE: begin
				req.ready = 1'b1;
				rec_re    = req.valid;
			end
			flm_pkg::FSM_LOOK: begin
				rec_we   = dec_rec_we;
				wt_we    = dec_wt_we;
				wt_re    = dec_wt_re;
				load_out = dec_has_rsp && slot_free;
			end
			flm_pkg::FSM_EMIT: begin
				load_out = slot_free;
				out_d    = pend_q;
			end
			flm_pkg::FSM_GRANT: begin
				load_out              = slot_free;
				out_d.dest_client     = wt_rd;
				out_d.status          = flm_pkg::ST_GRANTED;
				out_d.read_value      = '0;
				out_d.last            = 1'b1;
				rec_we                = slot_free;
				rec_wdata             = upd_q;
				rec_wdata.owned       = 1'b1;
				rec_wdata.owner       = wt_rd;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= flm_pkg::FSM_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			grant_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == flm_pkg::FSM_CLEAR) begin
				clr_q <= RIDX_W'(clr_q + 1'b1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == flm_pkg::FSM_LOOK) begin
				grant_q <= dec_grant;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q <= req.data.action;
			cli_q <= req.data.client_id;
			r_q   <= rmod_tab[req.data.resource_id];
			wv_q  <= req.data.write_value;
		end
		if (state_q == flm_pkg::FSM_LOOK) begin
			pend_q <= dec_rsp;
			upd_q  <= dec_rec;
		end
		if (load_out) begin
			out_data_q <= out_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;
endmodule

// ----- src/flm_checker.sv -----
// Port-level checks for the FIFO lock manager, bound to the top level.
`timescale 1ns / 1ps

module flm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input flm_pkg::rsp_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("reply changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	a_grant_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == flm_pkg::ST_GRANTED |-> rsp_data.last)
		else $error("grant not marked last");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != flm_pkg::ST_READ_OK |-> rsp_data.read_value == '0)
		else $error("nonzero value outside read_ok");

	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.last |-> rsp_data.status == flm_pkg::ST_UNLOCKED)
		else $error("non-final reply other than unlocked");
endmodule

bind fifo_lock_manager_unit flm_checker u_flm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the FIFO lock manager: directed and random requests checked against a lock table.

module tb;
	import flm_pkg::*;

	localparam int RES_COUNT   = NUM_RESOURCES_DEF;
	localparam int WAIT_DEPTH  = QUEUE_DEPTH_DEF;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int EXP_SLOTS   = 16;

	localparam logic [ACTION_W-1:0] ACT_UNKNOWN_FIRST = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LAST  = 3'd7;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_MOSTLY,
		SINK_TRICKLE
	} sink_mode_t;

	logic clk;
	logic arst_n;

	flm_chan_if #(.T(req_t)) req_if ();
	flm_chan_if #(.T(rsp_t)) rsp_if ();

	fifo_lock_manager_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	logic                lock_owned [RES_COUNT];
	logic [CLIENT_W-1:0] lock_owner [RES_COUNT];
	logic [VALUE_W-1:0]  res_value  [RES_COUNT];
	logic [CLIENT_W-1:0] waiter     [RES_COUNT][WAIT_DEPTH];
	int                  wait_head  [RES_COUNT];
	int                  wait_count [RES_COUNT];

	// expected replies, oldest at exp_rd
	rsp_t                exp_ring [EXP_SLOTS];
	int                  exp_wr    = 0;
	int                  exp_rd    = 0;
	int                  exp_level = 0;

	logic [CLIENT_W-1:0] client_pool [8];

	int         mismatches  = 0;
	int         idle_cycles = 0;
	int         burst_left  = 0;
	int         sink_left   = 0;
	int         sink_tick   = 0;
	sink_mode_t sink_mode   = SINK_OPEN;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic req_t make_req(logic [ACTION_W-1:0] act, logic [CLIENT_W-1:0] client,
			logic [RES_FIELD_W-1:0] res, logic [VALUE_W-1:0] value);
		req_t r;
		r.action      = act;
		r.client_id   = client;
		r.resource_id = res;
		r.write_value = value;
		return r;
	endfunction

	function automatic void add_reply(logic [CLIENT_W-1:0] client, status_t st,
			logic [VALUE_W-1:0] value, logic last);
		rsp_t rep;
		rep.dest_client = client;
		rep.status      = st;
		rep.read_value  = value;
		rep.last        = last;
		if (exp_level >= EXP_SLOTS) begin
			mismatches++;
			$display("%0t: expected-reply store full, expected room, got %0d entries",
				$time, exp_level);
		end else begin
			exp_ring[exp_wr] = rep;
			exp_wr = (exp_wr + 1) % EXP_SLOTS;
			exp_level++;
		end
	endfunction

	function automatic void predict_replies(req_t r);
		int   res;
		int   slot;
		logic owner_match;
		res = int'(r.resource_id) % RES_COUNT;
		owner_match = lock_owned[res] && lock_owner[res] == r.client_id;
		case (r.action)
		ACT_LOCK: begin
			if (!lock_owned[res]) begin
				lock_owned[res] = 1'b1;
				lock_owner[res] = r.client_id;
				add_reply(r.client_id, ST_GRANTED, '0, 1'b1);
			end else if (wait_count[res] >= WAIT_DEPTH) begin
				add_reply(r.client_id, ST_QUEUE_FULL, '0, 1'b1);
			end else begin
				// queued silently
				slot = (wait_head[res] + wait_count[res]) % WAIT_DEPTH;
				waiter[res][slot] = r.client_id;
				wait_count[res]++;
			end
		end
		ACT_WRITE: begin
			if (owner_match) begin
				res_value[res] = r.write_value;
				add_reply(r.client_id, ST_WRITE_OK, '0, 1'b1);
			end else begin
				add_reply(r.client_id, ST_WRITE_DENIED, '0, 1'b1);
			end
		end
		ACT_READ: begin
			if (owner_match) begin
				add_reply(r.client_id, ST_READ_OK, res_value[res], 1'b1);
			end else begin
				add_reply(r.client_id, ST_READ_DENIED, '0, 1'b1);
			end
		end
		ACT_UNLOCK: begin
			if (!owner_match) begin
				add_reply(r.client_id, ST_UNLOCK_DENIED, '0, 1'b1);
			end else if (wait_count[res] != 0) begin
				// hand over to the oldest waiter
				add_reply(r.client_id, ST_UNLOCKED, '0, 1'b0);
				lock_owner[res] = waiter[res][wait_head[res]];
				wait_head[res]  = (wait_head[res] + 1) % WAIT_DEPTH;
				wait_count[res]--;
				add_reply(lock_owner[res], ST_GRANTED, '0, 1'b1);
			end else begin
				lock_owned[res] = 1'b0;
				lock_owner[res] = '0;
				add_reply(r.client_id, ST_UNLOCKED, '0, 1'b1);
			end
		end
		default: begin
			add_reply(r.client_id, ST_UNKNOWN_OP, '0, 1'b1);
		end
		endcase
	endfunction

	task automatic push_request(req_t item);
		@(negedge clk);
		if (burst_left == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.data  <= item;
		do @(posedge clk); while (!req_if.ready);
		predict_replies(item);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (exp_level != 0) @(posedge clk);
	endtask

	function automatic logic [CLIENT_W-1:0] pick_client(int res, int owner_pct, int pool_size);
		if (lock_owned[res] && $urandom_range(0, 99) < owner_pct)
			return lock_owner[res];
		return client_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	function automatic logic [ACTION_W-1:0] pick_action(int lock_pct, int unlock_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < lock_pct)
			return ACT_LOCK;
		if (roll < lock_pct + unlock_pct)
			return ACT_UNLOCK;
		if (roll < 95)
			return $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
		return ACTION_W'($urandom_range(ACT_UNKNOWN_LAST, ACT_UNKNOWN_FIRST));
	endfunction

	task automatic run_random(int count, int res_lo, int res_hi, int pool_size,
			int lock_pct, int unlock_pct, int owner_pct);
		int                  res;
		logic [ACTION_W-1:0] act;
		for (int n = 0; n < count; n++) begin
			res = $urandom_range(res_lo, res_hi);
			act = pick_action(lock_pct, unlock_pct);
			push_request(make_req(act, pick_client(res, owner_pct, pool_size),
				res[RES_FIELD_W-1:0], $urandom()));
		end
	endtask

	task automatic refill_pool();
		foreach (client_pool[i])
			client_pool[i] = CLIENT_W'($urandom_range(0, 255));
	endtask

	task automatic test_unknown_actions();
		push_request(make_req(ACT_UNKNOWN_FIRST, 8'hFF, 4'hF, 32'hFFFF_FFFF));
		push_request(make_req(ACT_UNKNOWN_LAST, 8'h00, 4'h0, 32'h0000_0000));
	endtask

	task automatic test_free_resource();
		push_request(make_req(ACT_WRITE, 8'h11, 4'h3, 32'h1234_5678));
		push_request(make_req(ACT_READ, 8'h11, 4'h3, 32'h0));
		push_request(make_req(ACT_UNLOCK, 8'h11, 4'h3, 32'h0));
	endtask

	task automatic test_lock_sequence();
		push_request(make_req(ACT_LOCK, 8'h00, 4'h0, 32'h0));
		push_request(make_req(ACT_WRITE, 8'h00, 4'h0, 32'hFFFF_FFFF));
		push_request(make_req(ACT_READ, 8'h00, 4'h0, 32'h0));
		push_request(make_req(ACT_READ, 8'hFF, 4'h0, 32'h0));
		push_request(make_req(ACT_UNLOCK, 8'hFF, 4'h0, 32'h0));
		push_request(make_req(ACT_LOCK, 8'hFF, 4'h0, 32'h0));
		// owner locking again joins the queue
		push_request(make_req(ACT_LOCK, 8'h00, 4'h0, 32'h0));
		push_request(make_req(ACT_UNLOCK, 8'h00, 4'h0, 32'h0));
		push_request(make_req(ACT_READ, 8'hFF, 4'h0, 32'h0));
		push_request(make_req(ACT_UNLOCK, 8'hFF, 4'h0, 32'h0));
		push_request(make_req(ACT_UNLOCK, 8'h00, 4'h0, 32'h0));
	endtask

	task automatic test_queue_full();
		push_request(make_req(ACT_LOCK, 8'hFF, 4'hF, 32'h0));
		for (int i = 0; i < WAIT_DEPTH; i++)
			push_request(make_req(ACT_LOCK, 8'h80 + i[CLIENT_W-1:0], 4'hF, 32'h0));
		push_request(make_req(ACT_LOCK, 8'h01, 4'hF, 32'h0));
	endtask

	task automatic test_contention();
		refill_pool();
		run_random(550, 0, 3, 4, 35, 25, 70);
	endtask

	task automatic test_hot_queue();
		refill_pool();
		run_random(350, 14, 15, 8, 60, 25, 80);
	endtask

	task automatic test_broad();
		refill_pool();
		run_random(450, 0, RES_COUNT - 1, 8, 30, 25, 40);
	endtask

	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(SINK_OPEN, SINK_TRICKLE));
			sink_left = $urandom_range(40, 250);
		end
		sink_left--;
		sink_tick++;
		case (sink_mode)
		SINK_OPEN:   rsp_if.ready <= 1'b1;
		SINK_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
		SINK_MOSTLY: rsp_if.ready <= ($urandom_range(0, 7) != 0);
		default:     rsp_if.ready <= (sink_tick % 16 == 0);
		endcase
	end

	function automatic void check_field(string field, logic [VALUE_W-1:0] want,
			logic [VALUE_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_replies
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (exp_level == 0) begin
				mismatches++;
				$display("%0t: unexpected reply, expected none, got client %0h status %0h",
					$time, got.dest_client, got.status);
			end else begin
				want = exp_ring[exp_rd];
				exp_rd = (exp_rd + 1) % EXP_SLOTS;
				exp_level--;
				check_field("dest_client", want.dest_client, got.dest_client);
				check_field("status", want.status, got.status);
				check_field("read_value", want.read_value, got.read_value);
				check_field("last", want.last, got.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < RES_COUNT; i++) begin
			lock_owned[i] = 1'b0;
			lock_owner[i] = '0;
			res_value[i]  = '0;
			wait_head[i]  = 0;
			wait_count[i] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_unknown_actions();
		test_free_resource();
		test_lock_sequence();
		test_queue_full();
		wait_for_drain();
		test_contention();
		wait_for_drain();
		test_hot_queue();
		wait_for_drain();
		test_broad();
		wait_for_drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
